FILE: src/udec_pkg.sv
`default_nettype none
// Shared types and constants of the UTF-8 stream decoder.
package udec_pkg;

   localparam logic [20:0] REPL_CP    = 21'h00FFFD;
   localparam logic [7:0]  CONT_LOW   = 8'h80;
   localparam logic [7:0]  CONT_HIGH  = 8'hBF;
   localparam logic [7:0]  LEAD2_LOW  = 8'hC2;
   localparam logic [7:0]  LEAD2_HIGH = 8'hDF;
   localparam logic [7:0]  LEAD3_LOW  = 8'hE0;
   localparam logic [7:0]  LEAD3_SURR = 8'hED;
   localparam logic [7:0]  LEAD3_HIGH = 8'hEF;
   localparam logic [7:0]  LEAD4_LOW  = 8'hF0;
   localparam logic [7:0]  LEAD4_HIGH = 8'hF4;
   localparam logic [7:0]  E0_LOW     = 8'hA0;
   localparam logic [7:0]  ED_HIGH    = 8'h9F;
   localparam logic [7:0]  F0_LOW     = 8'h90;
   localparam logic [7:0]  F4_HIGH    = 8'h8F;

   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [20:0] scalar;
      logic        well_formed;
      logic [2:0]  byte_count;
      logic        last;
   } result_type;

   // up to two results produced by one item, first is delivered first
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage
`default_nettype wire

FILE: src/udec_core.sv
`default_nettype none
// Decode state and single-pass decode logic, one item per cycle.
module udec_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_valid,
   input  wire logic              item_mode,
   input  wire logic [7:0]        item_byte,
   output udec_pkg::push_type     push
);
   import udec_pkg::*;

   typedef struct packed {
      logic        emit;
      result_type  res;
      logic [1:0]  need;
      logic [20:0] partial;
      logic [7:0]  low;
      logic [7:0]  high;
   } lead_type;

   function automatic lead_type take_lead(input logic [7:0] b);
      lead_type l;
      l.emit             = 1'b0;
      l.res.scalar       = REPL_CP;
      l.res.well_formed  = 1'b0;
      l.res.byte_count   = 3'd1;
      l.res.last         = 1'b1;
      l.need             = 2'd0;
      l.partial          = 21'd0;
      l.low              = CONT_LOW;
      l.high             = CONT_HIGH;
      if (!b[7]) begin
         l.emit            = 1'b1;
         l.res.scalar      = {13'd0, b};
         l.res.well_formed = 1'b1;
      end else if (b >= LEAD2_LOW && b <= LEAD2_HIGH) begin
         l.need    = 2'd1;
         l.partial = {16'd0, b[4:0]};
      end else if (b >= LEAD3_LOW && b <= LEAD3_HIGH) begin
         l.need    = 2'd2;
         l.partial = {17'd0, b[3:0]};
         if (b == LEAD3_LOW) begin
            l.low = E0_LOW;
         end else if (b == LEAD3_SURR) begin
            l.high = ED_HIGH;
         end
      end else if (b >= LEAD4_LOW && b <= LEAD4_HIGH) begin
         l.need    = 2'd3;
         l.partial = {18'd0, b[2:0]};
         if (b == LEAD4_LOW) begin
            l.low = F0_LOW;
         end else if (b == LEAD4_HIGH) begin
            l.high = F4_HIGH;
         end
      end else begin
         l.emit = 1'b1;
      end
      return l;
   endfunction

   logic [1:0]  need_ff, need_in;
   logic [2:0]  seen_ff, seen_in;
   logic [20:0] partial_ff, partial_in;
   logic [7:0]  low_ff, low_in;
   logic [7:0]  high_ff, high_in;

   lead_type    lead;
   logic [20:0] shifted;
   logic [2:0]  seen_inc;
   logic        in_range;

   always_comb begin
      lead     = take_lead(item_byte);
      shifted  = {partial_ff[14:0], item_byte[5:0]};
      seen_inc = seen_ff + 3'd1;
      in_range = (item_byte >= low_ff) && (item_byte <= high_ff);

      need_in    = need_ff;
      seen_in    = seen_ff;
      partial_in = partial_ff;
      low_in     = low_ff;
      high_in    = high_ff;

      push.count              = 2'd0;
      push.first.scalar       = REPL_CP;
      push.first.well_formed  = 1'b0;
      push.first.byte_count   = seen_ff;
      push.first.last         = 1'b1;
      push.second             = lead.res;

      if (item_valid) begin
         if (item_mode) begin
            if (need_ff != 2'd0) begin
               push.count = 2'd1;
               need_in    = 2'd0;
               seen_in    = 3'd0;
               partial_in = 21'd0;
               low_in     = CONT_LOW;
               high_in    = CONT_HIGH;
            end
         end else if (need_ff != 2'd0 && in_range) begin
            low_in  = CONT_LOW;
            high_in = CONT_HIGH;
            if (need_ff == 2'd1) begin
               push.count             = 2'd1;
               push.first.scalar      = shifted;
               push.first.well_formed = 1'b1;
               push.first.byte_count  = seen_inc;
               need_in    = 2'd0;
               seen_in    = 3'd0;
               partial_in = 21'd0;
            end else begin
               need_in    = need_ff - 2'd1;
               seen_in    = seen_inc;
               partial_in = shifted;
            end
         end else begin
            need_in    = lead.need;
            seen_in    = (lead.need != 2'd0) ? 3'd1 : 3'd0;
            partial_in = lead.partial;
            low_in     = lead.low;
            high_in    = lead.high;
            if (need_ff != 2'd0) begin
               push.count      = lead.emit ? 2'd2 : 2'd1;
               push.first.last = ~lead.emit;
            end else begin
               push.count = lead.emit ? 2'd1 : 2'd0;
               push.first = lead.res;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         need_ff    <= 2'd0;
         seen_ff    <= 3'd0;
         partial_ff <= 21'd0;
         low_ff     <= CONT_LOW;
         high_ff    <= CONT_HIGH;
      end else begin
         need_ff    <= need_in;
         seen_ff    <= seen_in;
         partial_ff <= partial_in;
         low_ff     <= low_in;
         high_ff    <= high_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/udec_queue.sv
`default_nettype none
// Result queue: takes up to two results a cycle, delivers one.
module udec_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire udec_pkg::push_type   push,
   output logic                      has_room,
   output logic                      out_valid,
   input  wire logic                 out_take,
   output udec_pkg::result_type      out_item
);
   import udec_pkg::*;

   result_type                   entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0]   count_ff, count_in;
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_next;
   logic                         pop;

   assign out_valid   = (count_ff != '0);
   assign out_item    = entry_ff[rd_ptr_ff];
   assign has_room    = (count_ff <= QUEUE_CNT_WIDTH'(QUEUE_DEPTH - 2));
   assign pop         = out_valid & out_take;
   assign wr_ptr_next = wr_ptr_ff + QUEUE_PTR_WIDTH'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_WIDTH'(push.count);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_WIDTH'(pop);
      count_in  = count_ff + QUEUE_CNT_WIDTH'(push.count) - QUEUE_CNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/utf8_stream_decoder_top.sv
`default_nettype none
// Top level of the validating UTF-8 stream decoder.
// Takes one byte item per cycle, unless req_stall is high, into an input
// register; the decode logic updates the partial-sequence state and writes
// zero, one or two results into a four-entry result queue in the same
// cycle. A result passes the input register and then the queue. Sustained
// rate is one item per cycle while each item yields at most one result and
// rsp_stall is low; the port delivers one result per cycle, so an item
// ending a bad partial sequence with a second result slows the output. The
// input register holds while the queue has fewer than two free entries.
module utf8_stream_decoder_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_mode,
   input  wire logic [7:0]  req_in_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [20:0]      rsp_scalar,
   output logic             rsp_well_formed,
   output logic [2:0]       rsp_byte_count,
   output logic             rsp_last
);
   import udec_pkg::*;

   logic       in_valid_ff;
   logic       in_mode_ff;
   logic [7:0] in_byte_ff;
   logic       has_room;
   logic       advance;
   logic       load;
   push_type   push;
   result_type out_item;

   assign advance   = in_valid_ff & has_room;
   assign req_stall = in_valid_ff & ~has_room;
   assign load      = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (load) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_mode_ff <= req_mode;
         in_byte_ff <= req_in_byte;
      end
   end

   udec_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (advance),
      .item_mode  (in_mode_ff),
      .item_byte  (in_byte_ff),
      .push       (push)
   );

   udec_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .has_room  (has_room),
      .out_valid (rsp_valid),
      .out_take  (~rsp_stall),
      .out_item  (out_item)
   );

   assign rsp_scalar      = out_item.scalar;
   assign rsp_well_formed = out_item.well_formed;
   assign rsp_byte_count  = out_item.byte_count;
   assign rsp_last        = out_item.last;

endmodule
`default_nettype wire
